// ----- rtl/core/ufrt_pkg.sv -----
// Shared types and constants for the frame reassembly tracker.
// Holds sizing constants, the status codes and the header command that
// travels from the header checker to the frame tracker.
package ufrt_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 262144;
  localparam int unsigned CHUNK_BYTES     = 1024;
  localparam int unsigned HEADER_BYTES    = 20;

  localparam int unsigned CHUNK_SLOTS = (MAX_FRAME_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int unsigned CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int unsigned FRAME_W     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned IDX_W       = $clog2(CHUNK_SLOTS + 1);
  localparam int unsigned SLOT_W      = $clog2(CHUNK_SLOTS);
  localparam int unsigned LEN_W       = $clog2(CHUNK_BYTES + 1);

  localparam int unsigned OFFSET_W    = 18;
  localparam int unsigned STORE_LEN_W = 11;
  localparam int unsigned DONE_W      = 19;
  localparam int unsigned STATUS_W    = 3;

  localparam int unsigned IN_DATA_W  = 208;
  localparam int unsigned OUT_DATA_W = 88;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic {
    REG_MAGIC   = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_index_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INVALID   = 3'd0,
    ST_STALE     = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_STORED    = 3'd5,
    ST_COMPLETE  = 3'd6
  } status_e;

  typedef struct packed {
    logic               hdr_ok;
    logic [31:0]        pkt_id;
    logic [FRAME_W-1:0] frame_bytes;
    logic [IDX_W-1:0]   chunk_idx;
    logic [IDX_W-1:0]   chunks_new;
    logic [LEN_W-1:0]   payload_len;
    logic [31:0]        now_ms;
  } hdr_cmd_t;

endpackage

// ----- rtl/core/udp_frame_reassembly_tracker.sv -----
// Frame reassembly tracker for chunked datagrams, one header per transfer.
// A header is accepted every cycle while the two-entry queue has room; its
// result is registered in the frame tracker once it leaves the queue. The
// frame tracker's combinational update of the open frame and 256-flop chunk
// bitmap sets the sustained rate of one header per cycle while results are
// taken. Stalls on the result side back up into the queue, then into
// s_axis_tready.
// Depends on ufrt_pkg, ufrt_front, ufrt_fifo and ufrt_back.
module udp_frame_reassembly_tracker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [31:0]                     cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // datagram_length, header_magic, packet_frame_id, packet_frame_size,
  // packet_offset, payload_size, now_ms
  input  logic [ufrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // store_enable, store_offset, store_length, done_frame_bytes, frames_done
  output logic [ufrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [ufrt_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import ufrt_pkg::*;

  logic [31:0] magic_q;
  logic [31:0] timeout_q;
  hdr_cmd_t    front_cmd;
  hdr_cmd_t    back_cmd;
  logic        fifo_full;
  logic        fifo_empty;
  logic        fifo_pop;
  logic        fifo_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_MAGIC:   magic_q   <= cfg_wdata_i;
        REG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  assign s_axis_tready = !fifo_full;
  assign fifo_push     = s_axis_tvalid && !fifo_full;

  ufrt_front u_front (
    .hdr_data_i   (s_axis_tdata),
    .magic_word_i (magic_q),
    .cmd_o        (front_cmd)
  );

  ufrt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (front_cmd),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (back_cmd)
  );

  ufrt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timeout_ms_i (timeout_q),
    .cmd_valid_i  (!fifo_empty),
    .cmd_i        (back_cmd),
    .cmd_pop_o    (fifo_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser)
  );

endmodule

// ----- rtl/core/ufrt_front.sv -----
// Header checker: validates magic, sizes, length match, bounds and alignment.
// Produces a narrowed header command for the frame tracker; uses ufrt_pkg.
module ufrt_front (
  input  logic [ufrt_pkg::IN_DATA_W-1:0] hdr_data_i,
  input  logic [31:0]                    magic_word_i,
  output ufrt_pkg::hdr_cmd_t             cmd_o
);
  import ufrt_pkg::*;

  logic [15:0] dlen;
  logic [31:0] magic;
  logic [31:0] fid;
  logic [31:0] fsize;
  logic [31:0] offs;
  logic [31:0] psize;
  logic [31:0] now;
  logic [32:0] end_sum;
  logic [32:0] len_need;
  logic [FRAME_W:0] round_up;
  logic        bad;

  assign dlen  = hdr_data_i[15:0];
  assign magic = hdr_data_i[47:16];
  assign fid   = hdr_data_i[79:48];
  assign fsize = hdr_data_i[111:80];
  assign offs  = hdr_data_i[143:112];
  assign psize = hdr_data_i[175:144];
  assign now   = hdr_data_i[207:176];

  assign end_sum  = {1'b0, offs} + {1'b0, psize};
  assign len_need = 33'(HEADER_BYTES) + {1'b0, psize};
  assign round_up = {1'b0, fsize[FRAME_W-1:0]} + (FRAME_W + 1)'(CHUNK_BYTES - 1);

  assign bad = (dlen < 16'(HEADER_BYTES)) ||
               (magic != magic_word_i) ||
               (fsize > MAX_FRAME_BYTES) ||
               (psize > CHUNK_BYTES) ||
               ({17'b0, dlen} != len_need) ||
               (end_sum > {1'b0, fsize}) ||
               (offs[CHUNK_SHIFT-1:0] != '0);

  always_comb begin
    cmd_o.hdr_ok      = !bad;
    cmd_o.pkt_id      = fid;
    cmd_o.frame_bytes = fsize[FRAME_W-1:0];
    cmd_o.chunk_idx   = IDX_W'(offs >> CHUNK_SHIFT);
    cmd_o.chunks_new  = IDX_W'(round_up >> CHUNK_SHIFT);
    cmd_o.payload_len = psize[LEN_W-1:0];
    cmd_o.now_ms      = now;
  end

endmodule

// ----- rtl/core/ufrt_fifo.sv -----
// Short command queue between the header checker and the frame tracker.
// Flop storage of ufrt_pkg::FIFO_DEPTH header commands.
module ufrt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ufrt_pkg::hdr_cmd_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ufrt_pkg::hdr_cmd_t pop_data_o
);
  import ufrt_pkg::*;

  hdr_cmd_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;

  assign full_o     = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/ufrt_back.sv -----
// Frame tracker: applies header commands to the open frame and chunk bitmap.
// Drives the registered result transfer; uses ufrt_pkg.
module ufrt_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [31:0]                     timeout_ms_i,
  input  logic                            cmd_valid_i,
  input  ufrt_pkg::hdr_cmd_t              cmd_i,
  output logic                            cmd_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ufrt_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic [ufrt_pkg::STATUS_W-1:0]   out_user_o
);
  import ufrt_pkg::*;

  logic [31:0]          open_id_q, open_id_d;
  logic [FRAME_W-1:0]   open_bytes_q, open_bytes_d;
  logic [FRAME_W-1:0]   bytes_rx_q, bytes_rx_d;
  logic [IDX_W-1:0]     chunks_exp_q, chunks_exp_d;
  logic [IDX_W-1:0]     chunks_rx_q, chunks_rx_d;
  logic [CHUNK_SLOTS-1:0] seen_q, seen_d;
  logic [31:0]          start_q, start_d;
  logic [31:0]          count_q, count_d;

  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic                 st_en_q, st_en_d;
  logic [OFFSET_W-1:0]  st_off_q, st_off_d;
  logic [STORE_LEN_W-1:0] st_len_q, st_len_d;
  logic [DONE_W-1:0]    done_q, done_d;

  logic [31:0]          age;
  logic                 timed_out;
  logic [SLOT_W-1:0]    slot;

  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign age       = cmd_i.now_ms - start_q;
  assign timed_out = (open_bytes_q != '0) && (cmd_i.pkt_id == open_id_q) &&
                     (age > timeout_ms_i);
  assign slot      = cmd_i.chunk_idx[SLOT_W-1:0];

  always_comb begin
    open_id_d    = open_id_q;
    open_bytes_d = open_bytes_q;
    bytes_rx_d   = bytes_rx_q;
    chunks_exp_d = chunks_exp_q;
    chunks_rx_d  = chunks_rx_q;
    seen_d       = seen_q;
    start_d      = start_q;
    count_d      = count_q;
    status_d     = ST_INVALID;
    st_en_d      = 1'b0;
    st_off_d     = '0;
    st_len_d     = '0;
    done_d       = '0;
    priority if (!cmd_i.hdr_ok) begin
      status_d = ST_INVALID;
    end else if (timed_out) begin
      open_bytes_d = '0;
      bytes_rx_d   = '0;
      chunks_rx_d  = '0;
      status_d     = ST_TIMEOUT;
    end else if (cmd_i.pkt_id < open_id_q) begin
      status_d = ST_STALE;
    end else begin
      if (cmd_i.pkt_id != open_id_q) begin
        open_id_d    = cmd_i.pkt_id;
        open_bytes_d = cmd_i.frame_bytes;
        bytes_rx_d   = '0;
        chunks_exp_d = cmd_i.chunks_new;
        chunks_rx_d  = '0;
        seen_d       = '0;
        start_d      = cmd_i.now_ms;
      end
      if ((cmd_i.frame_bytes != open_bytes_d) || (cmd_i.chunk_idx >= chunks_exp_d) ||
          (cmd_i.chunk_idx >= IDX_W'(CHUNK_SLOTS))) begin
        status_d = ST_MISMATCH;
      end else begin
        if (!seen_d[slot]) begin
          seen_d[slot] = 1'b1;
          bytes_rx_d   = bytes_rx_d + FRAME_W'(cmd_i.payload_len);
          chunks_rx_d  = chunks_rx_d + 1'b1;
          st_en_d      = 1'b1;
          st_off_d     = OFFSET_W'({slot, {CHUNK_SHIFT{1'b0}}});
          st_len_d     = STORE_LEN_W'(cmd_i.payload_len);
          status_d     = ST_STORED;
        end else begin
          status_d = ST_DUPLICATE;
        end
        if ((bytes_rx_d >= open_bytes_d) && (chunks_rx_d >= chunks_exp_d)) begin
          count_d      = count_q + 1'b1;
          done_d       = DONE_W'(open_bytes_d);
          open_bytes_d = '0;
          bytes_rx_d   = '0;
          chunks_rx_d  = '0;
          status_d     = ST_COMPLETE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_id_q    <= '0;
      open_bytes_q <= '0;
      bytes_rx_q   <= '0;
      chunks_exp_q <= '0;
      chunks_rx_q  <= '0;
      seen_q       <= '0;
      start_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        open_id_q    <= open_id_d;
        open_bytes_q <= open_bytes_d;
        bytes_rx_q   <= bytes_rx_d;
        chunks_exp_q <= chunks_exp_d;
        chunks_rx_q  <= chunks_rx_d;
        seen_q       <= seen_d;
        start_q      <= start_d;
        count_q      <= count_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      status_q <= status_d;
      st_en_q  <= st_en_d;
      st_off_q <= st_off_d;
      st_len_q <= st_len_d;
      done_q   <= done_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = status_q;
  assign out_data_o  = {7'b0, count_q, done_q, st_len_q, st_off_q, st_en_q};

endmodule

// ----- verif/udp_frame_reassembly_tracker_test.sv -----
// Self-checking testbench for udp_frame_reassembly_tracker: directed header, frame and
// timeout cases, backpressure and random traffic checked against an in-bench tracker model.
// Depends on ufrt_pkg and the RTL under rtl/core.
module udp_frame_reassembly_tracker_test;
  import ufrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] payload_size;
    logic [31:0] packet_offset;
    logic [31:0] pkt_bytes;
    logic [31:0] pkt_id;
    logic [31:0] header_magic;
    logic [15:0] datagram_length;
  } header_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] frames_done;
    logic [18:0] done_bytes;
    logic [10:0] store_len;
    logic [17:0] store_off;
    logic        store_en;
  } outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_index_i = 1'b0;
  logic [31:0]           cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // tracker model state
  logic [31:0]            magic_cfg = '0;
  logic [31:0]            timeout_cfg = TIMEOUT_RESET;
  logic [31:0]            open_id_q = '0;
  int unsigned            open_bytes_q = 0;
  int unsigned            rx_bytes_q = 0;
  int unsigned            chunks_exp_q = 0;
  int unsigned            chunks_rx_q = 0;
  logic [CHUNK_SLOTS-1:0] seen_chunks_q = '0;
  logic [31:0]            start_ms_q = '0;
  logic [31:0]            done_count_q = '0;

  outcome_t    expected_outcomes[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit          hold_req = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned now_step_max = 12;
  logic [31:0] now_t = 32'd200;
  logic [31:0] next_fid = 32'd16;

  udp_frame_reassembly_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL udp_frame_reassembly_tracker");
        $finish;
      end
    end
  end

  initial begin
    wait (hold_req);
    hold_cycles = HOLD_CYCLES;
    while (hold_cycles > 0) begin
      @(posedge clk_i);
      hold_cycles--;
    end
  end

  function automatic outcome_t track_header(header_t h);
    outcome_t    o;
    logic [32:0] span;
    logic [32:0] want_len;
    logic [31:0] age;
    int unsigned slot;
    o.status = ST_INVALID;
    o.frames_done = '0;
    o.done_bytes = '0;
    o.store_len = '0;
    o.store_off = '0;
    o.store_en = 1'b0;
    span = {1'b0, h.packet_offset} + {1'b0, h.payload_size};
    want_len = 33'(HEADER_BYTES) + {1'b0, h.payload_size};
    age = h.now_ms - start_ms_q;
    if (h.datagram_length < HEADER_BYTES || h.header_magic != magic_cfg ||
        h.pkt_bytes > MAX_FRAME_BYTES || h.payload_size > CHUNK_BYTES ||
        {17'b0, h.datagram_length} != want_len || span > {1'b0, h.pkt_bytes} ||
        h.packet_offset % CHUNK_BYTES != 0) begin
      o.status = ST_INVALID;
    end else if (open_bytes_q > 0 && h.pkt_id == open_id_q && age > timeout_cfg) begin
      open_bytes_q = 0;
      rx_bytes_q = 0;
      chunks_rx_q = 0;
      o.status = ST_TIMEOUT;
    end else if (h.pkt_id < open_id_q) begin
      o.status = ST_STALE;
    end else begin
      if (h.pkt_id != open_id_q) begin
        open_id_q = h.pkt_id;
        open_bytes_q = h.pkt_bytes;
        rx_bytes_q = 0;
        chunks_exp_q = (h.pkt_bytes + CHUNK_BYTES - 1) / CHUNK_BYTES;
        chunks_rx_q = 0;
        seen_chunks_q = '0;
        start_ms_q = h.now_ms;
      end
      slot = h.packet_offset / CHUNK_BYTES;
      if (h.pkt_bytes != open_bytes_q || slot >= chunks_exp_q || slot >= CHUNK_SLOTS) begin
        o.status = ST_MISMATCH;
      end else begin
        if (!seen_chunks_q[slot]) begin
          seen_chunks_q[slot] = 1'b1;
          rx_bytes_q += h.payload_size;
          chunks_rx_q++;
          o.store_en = 1'b1;
          o.store_off = h.packet_offset[17:0];
          o.store_len = h.payload_size[10:0];
          o.status = ST_STORED;
        end else begin
          o.status = ST_DUPLICATE;
        end
        if (rx_bytes_q >= open_bytes_q && chunks_rx_q >= chunks_exp_q) begin
          done_count_q++;
          o.done_bytes = open_bytes_q[18:0];
          open_bytes_q = 0;
          rx_bytes_q = 0;
          chunks_rx_q = 0;
          o.status = ST_COMPLETE;
        end
      end
    end
    o.frames_done = done_count_q;
    return o;
  endfunction

  function automatic header_t build_header(logic [31:0] fid, logic [31:0] fsize,
                                           logic [31:0] offs, logic [31:0] psize,
                                           logic [31:0] now);
    header_t h;
    h.now_ms = now;
    h.payload_size = psize;
    h.packet_offset = offs;
    h.pkt_bytes = fsize;
    h.pkt_id = fid;
    h.header_magic = magic_cfg;
    h.datagram_length = 16'(HEADER_BYTES + psize);
    return h;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual status %0d data 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
        check_field("store_enable", 32'(want.store_en), 32'(m_axis_tdata[0]));
        check_field("store_offset", 32'(want.store_off), 32'(m_axis_tdata[18:1]));
        check_field("store_length", 32'(want.store_len), 32'(m_axis_tdata[29:19]));
        check_field("done_frame_bytes", 32'(want.done_bytes), 32'(m_axis_tdata[48:30]));
        check_field("frames_done", want.frames_done, m_axis_tdata[80:49]);
      end
    end
    m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic send_header(header_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= h;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_outcomes.push_back(track_header(h));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAGIC) magic_cfg = value;
    else timeout_cfg = value;
  endtask

  task automatic test_reset_frame_zero();
    header_t h;
    h = build_header(0, 0, 0, 0, 100);
    h.datagram_length = 16'd19;
    send_header(h);
    h.datagram_length = 16'd0;
    send_header(h);
    send_header(build_header(0, 0, 0, 0, 100));
    send_header(build_header(0, CHUNK_BYTES, 0, CHUNK_BYTES, 100));
  endtask

  task automatic test_header_checks();
    header_t h;
    drain_results();
    write_reg(REG_MAGIC, 32'h5A3C_96E1);
    write_reg(REG_TIMEOUT, TIMEOUT_RESET);
    h = build_header(1, CHUNK_BYTES, 0, CHUNK_BYTES, 100);
    h.header_magic = ~magic_cfg;
    send_header(h);
    h = build_header(1, CHUNK_BYTES, 0, 0, 100);
    h.payload_size = '1;
    h.datagram_length = '1;
    send_header(h);
    send_header(build_header(1, 32'hFFFF_FFFF, 0, CHUNK_BYTES, 100));
    send_header(build_header(1, MAX_FRAME_BYTES + 1, 0, CHUNK_BYTES, 100));
    h = build_header(1, 2048, 0, 512, 100);
    h.datagram_length -= 16'd1;
    send_header(h);
    send_header(build_header(1, MAX_FRAME_BYTES, 32'hFFFF_FC00, CHUNK_BYTES, 100));
    send_header(build_header(1, 2048, 512, 100, 100));
  endtask

  task automatic test_frame_tracking();
    send_header(build_header(5, 0, 0, 0, 100));
    send_header(build_header(6, 2500, 0, CHUNK_BYTES, 100));
    send_header(build_header(6, 2500, 0, CHUNK_BYTES, 100));
    send_header(build_header(6, 2500, 2048, 452, 100));
    send_header(build_header(4, 2500, 0, CHUNK_BYTES, 100));
    send_header(build_header(6, 3000, CHUNK_BYTES, CHUNK_BYTES, 100));
    send_header(build_header(6, 2500, CHUNK_BYTES, CHUNK_BYTES, 100));
    send_header(build_header(6, 2500, 0, CHUNK_BYTES, 100));
    send_header(build_header(6, 0, 0, 0, 100));
    send_header(build_header(7, MAX_FRAME_BYTES, MAX_FRAME_BYTES - CHUNK_BYTES,
                             CHUNK_BYTES, 100));
  endtask

  task automatic test_timeout_close();
    drain_results();
    write_reg(REG_TIMEOUT, 32'd0);
    send_header(build_header(7, MAX_FRAME_BYTES, 0, CHUNK_BYTES, 101));
    drain_results();
    write_reg(REG_TIMEOUT, 32'd100);
    send_header(build_header(9, 2048, 0, CHUNK_BYTES, 32'hFFFF_FFF0));
    send_header(build_header(9, 2048, CHUNK_BYTES, CHUNK_BYTES, 32'h0000_0050));
    send_header(build_header(10, 2048, 0, CHUNK_BYTES, 32'hFFFF_FFF0));
    send_header(build_header(10, 2048, CHUNK_BYTES, CHUNK_BYTES, 32'h0000_0060));
  endtask

  task automatic test_backpressure();
    int unsigned saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    next_fid += 1;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_header(build_header(next_fid, 30 * CHUNK_BYTES, i * CHUNK_BYTES, CHUNK_BYTES, now_t));
    end
    send_idle_pct = saved_pct;
  endtask

  task automatic test_random_traffic(logic [31:0] magic, logic [31:0] timeout,
                                     int unsigned step_max, int unsigned n_items,
                                     bit with_full_frame);
    int unsigned sent, fsize, n_chunks, n_send, j, tmp, psize;
    int unsigned slot_order[CHUNK_SLOTS];
    header_t     h, bad;
    drain_results();
    write_reg(REG_MAGIC, magic);
    write_reg(REG_TIMEOUT, timeout);
    now_step_max = step_max;
    sent = 0;
    while (sent < n_items) begin
      next_fid += $urandom_range(1, 3);
      if (with_full_frame) begin
        fsize = MAX_FRAME_BYTES;
        with_full_frame = 1'b0;
      end else if ($urandom_range(99) < 5) begin
        fsize = 0;
      end else begin
        fsize = $urandom_range(1, 8 * CHUNK_BYTES);
      end
      n_chunks = (fsize + CHUNK_BYTES - 1) / CHUNK_BYTES;
      if (n_chunks == 0) n_chunks = 1;
      for (int i = 0; i < n_chunks; i++) slot_order[i] = i;
      for (int i = n_chunks - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = slot_order[i];
        slot_order[i] = slot_order[j];
        slot_order[j] = tmp;
      end
      n_send = (n_chunks > 1 && $urandom_range(24) == 0) ? n_chunks - 1 : n_chunks;
      for (int i = 0; i < n_send; i++) begin
        psize = fsize - slot_order[i] * CHUNK_BYTES;
        if (psize > CHUNK_BYTES) psize = CHUNK_BYTES;
        h = build_header(next_fid, fsize, slot_order[i] * CHUNK_BYTES, psize, now_t);
        if ($urandom_range(99) < 20) begin
          bad = h;
          case ($urandom_range(6))
            0: begin
              bad.datagram_length = 16'($urandom_range(0, 65535));
              bad.header_magic = $urandom;
              bad.pkt_id = $urandom;
              bad.pkt_bytes = $urandom;
              bad.packet_offset = $urandom;
              bad.payload_size = $urandom;
              bad.now_ms = $urandom;
            end
            1: bad.header_magic ^= 32'd1 << $urandom_range(31);
            2: bad.pkt_id = next_fid - $urandom_range(1, 15);
            3: bad.pkt_bytes = $urandom_range(0, MAX_FRAME_BYTES);
            4: bad.packet_offset += $urandom_range(1, CHUNK_BYTES - 1);
            5: bad.datagram_length += 16'($urandom_range(1, 40));
            default: bad = h;
          endcase
          send_header(bad);
          sent++;
        end
        if ($urandom_range(19) == 0) begin
          h.payload_size = $urandom_range(h.payload_size);
          h.datagram_length = 16'(HEADER_BYTES + h.payload_size);
        end
        send_header(h);
        sent++;
        now_t += $urandom_range(0, now_step_max);
      end
    end
  endtask

  task automatic test_frame_id_limit();
    send_header(build_header(32'hFFFF_FFFF, CHUNK_BYTES, 0, CHUNK_BYTES, now_t));
    send_header(build_header(32'hFFFF_FFFE, CHUNK_BYTES, 0, CHUNK_BYTES, now_t));
  endtask

  initial begin
    set_idling(16, 84);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_frame_zero();
    test_header_checks();
    test_frame_tracking();
    test_timeout_close();
    test_random_traffic($urandom, 32'd60, 12, 410, 1'b0);
    test_backpressure();
    set_idling(84, 16);
    test_random_traffic(32'hFFFF_FFFF, 32'd0, 1, 410, 1'b0);
    set_idling(0, 0);
    now_t = 32'hFFFF_FE00;
    test_random_traffic(32'h0000_0000, 32'hFFFF_FFFF, 12, 410, 1'b1);
    test_frame_id_limit();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS udp_frame_reassembly_tracker");
    end else begin
      $display("FAIL udp_frame_reassembly_tracker");
    end
    $finish;
  end

endmodule
